// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define PPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define PPS_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/pps_pkg.sv
// Shared types, constants and tables for the pure pursuit steering unit.
// No dependencies.
package pps_pkg;

   // Sizes
   localparam int PATH_DEPTH   = 1024;
   localparam int CORDIC_STEPS = 16;
   localparam int ADDR_W  = $clog2(PATH_DEPTH);
   localparam int CNT_W   = $clog2(PATH_DEPTH + 1);
   localparam int PTS_W   = 11;
   localparam int NUM_W   = (CNT_W > PTS_W) ? CNT_W : PTS_W;
   localparam int STEP_W  = $clog2(CORDIC_STEPS);
   localparam int XW      = 52;   // CORDIC vector width
   localparam int ZW      = 26;   // CORDIC angle width, Q20
   localparam int CW      = 23;   // heading sine/cosine, Q20
   localparam int DW      = 25;   // coordinate difference
   localparam int DIST_W  = 50;   // squared distance
   localparam int LW      = 49;   // point in vehicle frame
   localparam int PW      = 37;   // 2 * wheelbase * sine
   localparam int PT_W    = 48;   // stored point, east over north

   // Fixed-point constants
   localparam int GAIN_Q20    = 636751;
   localparam int PI_Q13      = 25736;
   localparam int HALF_PI_Q13 = 12868;
   localparam logic signed [15:0] ONE_Q13 = 16'sd8192;
   localparam logic signed [15:0] PT8_Q13 = 16'sd6554;
   localparam logic signed [15:0] PT2_Q13 = 16'sd1638;

   // Item function codes
   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_FLAG = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   // Mode flag codes
   localparam logic [7:0] FLAG_TRACK = 8'd0;
   localparam logic [7:0] FLAG_LEFT  = 8'd1;
   localparam logic [7:0] FLAG_RIGHT = 8'd2;
   localparam logic [7:0] FLAG_HARD  = 8'd3;

   // Result status codes
   localparam logic [1:0] STAT_TRACK = 2'd0;
   localparam logic [1:0] STAT_AVOID = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_NOFWD = 2'd3;

   // Register indexes
   localparam logic [2:0] CSR_WHEELBASE   = 3'd0;
   localparam logic [2:0] CSR_LOOKAHEAD   = 3'd1;
   localparam logic [2:0] CSR_TRACK_SPEED = 3'd2;
   localparam logic [2:0] CSR_AVOID_SPEED = 3'd3;
   localparam logic [2:0] CSR_PATH_POINTS = 3'd4;

   typedef enum logic [1:0] {
      MODE_TRACK = 2'd0,
      MODE_LEFT  = 2'd1,
      MODE_RIGHT = 2'd2
   } drive_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEAD,
      ST_NEAR,
      ST_AHEAD,
      ST_BEAR,
      ST_SIN,
      ST_MUL,
      ST_STEER,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [9:0]         point_index;
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic [7:0]         mode_flag;
      logic signed [23:0] vehicle_x;
      logic signed [23:0] vehicle_y;
      logic signed [15:0] heading;
   } req_type;

   typedef struct packed {
      logic signed [15:0] steering;
      logic [11:0]        speed;
      logic [1:0]         status;
      logic [9:0]         nearest_index;
   } rsp_type;

   // Start command for the shared CORDIC unit
   typedef struct packed {
      logic                 start;
      logic                 rot;     // 1 rotate, 0 vectoring
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_req_type;

   // One evaluated path point leaving the scan pipeline
   typedef struct packed {
      logic                 v;
      logic                 last;
      logic [ADDR_W-1:0]    idx;
      logic [DIST_W-1:0]    dsq;
      logic signed [LW-1:0] lx;
      logic signed [LW-1:0] ly;
   } scan_res_type;

   // atan(2^-i) in Q20
   function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
      logic signed [ZW-1:0] a;
      unique case (i)
         5'd0:  a = ZW'(823550);
         5'd1:  a = ZW'(486170);
         5'd2:  a = ZW'(256879);
         5'd3:  a = ZW'(130396);
         5'd4:  a = ZW'(65451);
         5'd5:  a = ZW'(32757);
         5'd6:  a = ZW'(16383);
         5'd7:  a = ZW'(8192);
         5'd8:  a = ZW'(4096);
         5'd9:  a = ZW'(2048);
         5'd10: a = ZW'(1024);
         5'd11: a = ZW'(512);
         5'd12: a = ZW'(256);
         5'd13: a = ZW'(128);
         5'd14: a = ZW'(64);
         5'd15: a = ZW'(32);
         5'd16: a = ZW'(16);
         5'd17: a = ZW'(8);
         5'd18: a = ZW'(4);
         5'd19: a = ZW'(2);
         5'd20: a = ZW'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// File: rtl/pps_path_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pps_path_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

// File: rtl/pps_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on pps_pkg for widths and the arctangent table.
module pps_cordic import pps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cordic_req_type       req,
   output logic                 done,
   output logic signed [XW-1:0] x_out,
   output logic signed [XW-1:0] y_out,
   output logic signed [ZW-1:0] z_out
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rot_ff, rot_in;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [XW-1:0] xs, ys;
   logic signed [ZW-1:0] ang;
   logic                 pos;

   // One micro-rotation
   always_comb begin
      xs  = x_ff >>> step_ff;
      ys  = y_ff >>> step_ff;
      ang = atan_q20(5'(step_ff));
      pos = rot_ff ? !z_ff[ZW-1] : y_ff[XW-1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rot_in  = rot_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rot_in  = req.rot;
         x_in    = $signed(req.x);
         y_in    = $signed(req.y);
         z_in    = $signed(req.z);
      end else if (busy_ff) begin
         if (pos) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

// File: rtl/pps_scan.sv
// Point evaluation pipeline: store read data -> offsets -> products -> sums.
// Depends on pps_pkg; fed by the path RAM read port.
module pps_scan import pps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 flush,
   input  logic                 issue_v,
   input  logic                 issue_last,
   input  logic [ADDR_W-1:0]    issue_idx,
   input  logic [PT_W-1:0]      rdata,
   input  logic signed [23:0]   vx,
   input  logic signed [23:0]   vy,
   input  logic signed [CW-1:0] c,
   input  logic signed [CW-1:0] s,
   output scan_res_type         res
);

   // Tags travel beside the data
   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic                     last1_ff, last2_ff, last3_ff, last4_ff;
   logic [ADDR_W-1:0]        idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic signed [DW-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic signed [2*DW-1:0]   sxx_ff, syy_ff;
   logic signed [CW+DW-1:0]  cdx_ff, sdy_ff, cdy_ff, sdx_ff;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic signed [LW-1:0]     lx_ff, lx_in, ly_ff, ly_in;
   logic signed [23:0]       east, north;

   // Offsets from the vehicle
   always_comb begin
      east  = $signed(rdata[PT_W-1:24]);
      north = $signed(rdata[23:0]);
      dx_in = DW'(east) - DW'(vx);
      dy_in = DW'(north) - DW'(vy);
   end

   // Squared distance and rotation into the vehicle frame
   always_comb begin
      dist_in = DIST_W'(sxx_ff[2*DW-2:0]) + DIST_W'(syy_ff[2*DW-2:0]);
      lx_in   = LW'(cdx_ff) + LW'(sdy_ff);
      ly_in   = LW'(cdy_ff) - LW'(sdx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= issue_v;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      last1_ff <= issue_last;
      last2_ff <= last1_ff;
      last3_ff <= last2_ff;
      last4_ff <= last3_ff;
      idx1_ff  <= issue_idx;
      idx2_ff  <= idx1_ff;
      idx3_ff  <= idx2_ff;
      idx4_ff  <= idx3_ff;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sxx_ff   <= dx_ff * dx_ff;
      syy_ff   <= dy_ff * dy_ff;
      cdx_ff   <= c * dx_ff;
      sdy_ff   <= s * dy_ff;
      cdy_ff   <= c * dy_ff;
      sdx_ff   <= s * dx_ff;
      dist_ff  <= dist_in;
      lx_ff    <= lx_in;
      ly_ff    <= ly_in;
   end

   always_comb begin
      res.v    = v4_ff;
      res.last = last4_ff;
      res.idx  = idx4_ff;
      res.dsq  = dist_ff;
      res.lx   = lx_ff;
      res.ly   = ly_ff;
   end

endmodule

// File: rtl/pure_pursuit_steering_unit.sv
// Pure pursuit steering unit: path store, mode flags, per-tick steering command.
// Load and flag items are applied on their transfer. A tracking tick makes one
// store read per cycle over two scans, plus four runs of the shared CORDIC, and
// the next input transfer is taken once its result is loaded for output.
// Sync reset clears control state and loads register defaults; store not cleared.
module pure_pursuit_steering_unit import pps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   seq_state_type state_ff, state_in;

   // Configuration registers
   logic [11:0]      wheelbase_ff, track_speed_ff, avoid_speed_ff;
   logic [15:0]      lookahead_ff;
   logic [PTS_W-1:0] path_points_ff;

   drive_mode_type mode_ff;
   logic           hard_ff;

   logic                 req_acc, tick_acc, flag_acc, load_acc;
   logic signed [23:0]   vx_ff, vy_ff;
   logic                 flip_ff, flip_in;
   logic signed [16:0]   hd_full, hd_fold;
   logic signed [CW-1:0] c_ff, s_ff, cx, sx;
   logic [31:0]          la2_ff;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [ADDR_W-1:0]    near_ff, near_in, last_addr;
   logic [DIST_W-1:0]    bd_ff, bd_in;
   logic signed [PW-1:0] prod_ff;
   logic [ADDR_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                 issuing_ff, issuing_in;
   logic                 scanning, issue_v, issue_last;
   logic                 hit, near_upd;
   rsp_type              res_ff, res_in, avoid_res, rsp_ff;
   logic                 res_set, hard_clear, rsp_load;
   logic                 rsp_valid_ff;

   cordic_req_type       creq;
   logic                 cdone;
   logic signed [XW-1:0] cx_out, cy_out;
   logic signed [ZW-1:0] cz_out;
   logic signed [ZW-1:0] dz;

   logic                 ram_we;
   logic [PT_W-1:0]      rdata;
   scan_res_type         sr;

   // Input transfers are taken only when idle
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign load_acc  = req_acc && (req_data.func == FUNC_LOAD);
   assign flag_acc  = req_acc && (req_data.func == FUNC_FLAG);
   assign tick_acc  = req_acc && (req_data.func == FUNC_TICK);
   assign ram_we    = load_acc && (32'(req_data.point_index) < PATH_DEPTH);

   // Point count clamped to the store depth
   always_comb begin
      if (NUM_W'(path_points_ff) > NUM_W'(PATH_DEPTH)) begin
         n_in = CNT_W'(PATH_DEPTH);
      end else begin
         n_in = CNT_W'(path_points_ff);
      end
   end

   // Heading folded into +-pi/2
   always_comb begin
      hd_full = 17'(req_data.heading);
      flip_in = 1'b0;
      hd_fold = hd_full;
      if (hd_full > 17'sd12868) begin
         hd_fold = hd_full - 17'(PI_Q13);
         flip_in = 1'b1;
      end else if (hd_full < -17'sd12868) begin
         hd_fold = hd_full + 17'(PI_Q13);
         flip_in = 1'b1;
      end
   end

   assign scanning  = (state_ff == ST_NEAR) || (state_ff == ST_AHEAD);
   assign last_addr = ADDR_W'(n_ff - 1'b1);
   assign issue_v   = scanning && issuing_ff;
   assign issue_last = (scan_idx_ff == last_addr);
   assign near_upd  = sr.v && ((sr.idx == '0) || (sr.dsq < bd_ff));
   assign hit = sr.v && !sr.lx[LW-1] && (sr.lx != '0) &&
                ((sr.dsq >= DIST_W'(la2_ff)) || sr.last);
   assign dz  = cz_out + ZW'(64);

   // Nearest point tracking
   always_comb begin
      near_in = near_ff;
      bd_in   = bd_ff;
      if (tick_acc) begin
         near_in = '0;
      end else if ((state_ff == ST_NEAR) && near_upd) begin
         near_in = sr.idx;
         bd_in   = sr.dsq;
      end
   end

   // Fixed avoid command
   always_comb begin
      avoid_res               = '0;
      avoid_res.speed         = avoid_speed_ff;
      avoid_res.status        = STAT_AVOID;
      if (hard_ff) begin
         avoid_res.steering = ONE_Q13;
      end else if (mode_ff == MODE_RIGHT) begin
         avoid_res.steering = PT8_Q13;
      end else begin
         avoid_res.steering = PT2_Q13;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (tick_acc) state_in = ST_HEAD;
         ST_HEAD: begin
            if (cdone) state_in = (n_ff == '0) ? ST_DONE : ST_NEAR;
         end
         ST_NEAR: begin
            if (sr.v && sr.last) begin
               state_in = (mode_ff != MODE_TRACK) ? ST_DONE : ST_AHEAD;
            end
         end
         ST_AHEAD: begin
            if (hit) state_in = ST_BEAR;
            else if (sr.v && sr.last) state_in = ST_DONE;
         end
         ST_BEAR:  if (cdone) state_in = ST_SIN;
         ST_SIN:   if (cdone) state_in = ST_MUL;
         ST_MUL:   state_in = ST_STEER;
         ST_STEER: if (cdone) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      creq        = '0;
      res_set     = 1'b0;
      res_in      = '0;
      hard_clear  = 1'b0;
      issuing_in  = issuing_ff;
      scan_idx_in = scan_idx_ff;
      rsp_load    = 1'b0;
      if (issue_v) begin
         scan_idx_in = scan_idx_ff + 1'b1;
         if (issue_last) issuing_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_acc) begin
               creq.start = 1'b1;
               creq.rot   = 1'b1;
               creq.x     = XW'(GAIN_Q20);
               creq.z     = ZW'(hd_fold) <<< 7;
            end
         end
         ST_HEAD: begin
            if (cdone) begin
               if (n_ff == '0) begin
                  res_set = 1'b1;
                  if (mode_ff != MODE_TRACK) begin
                     res_in     = avoid_res;
                     hard_clear = 1'b1;
                  end else begin
                     res_in.status = STAT_EMPTY;
                  end
               end else begin
                  issuing_in  = 1'b1;
                  scan_idx_in = '0;
               end
            end
         end
         ST_NEAR: begin
            if (sr.v && sr.last) begin
               if (mode_ff != MODE_TRACK) begin
                  res_set    = 1'b1;
                  res_in     = avoid_res;
                  hard_clear = 1'b1;
               end else begin
                  issuing_in  = 1'b1;
                  scan_idx_in = near_in;
               end
            end
         end
         ST_AHEAD: begin
            if (hit) begin
               issuing_in = 1'b0;
               creq.start = 1'b1;
               creq.x     = XW'(sr.lx);
               creq.y     = XW'(sr.ly);
            end else if (sr.v && sr.last) begin
               res_set       = 1'b1;
               res_in.status = STAT_NOFWD;
            end
         end
         ST_BEAR: begin
            if (cdone) begin
               creq.start = 1'b1;
               creq.rot   = 1'b1;
               creq.x     = XW'(GAIN_Q20);
               creq.z     = cz_out;
            end
         end
         ST_SIN: ;
         ST_MUL: begin
            creq.start = 1'b1;
            creq.x     = $signed({{(XW - 36){1'b0}}, lookahead_ff, 20'd0});
            creq.y     = XW'(prod_ff);
         end
         ST_STEER: begin
            if (cdone) begin
               res_set         = 1'b1;
               res_in.steering = dz[22:7];
               res_in.speed    = track_speed_ff;
               res_in.status   = STAT_TRACK;
            end
         end
         ST_DONE:  rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // Heading sine and cosine after the fold
   always_comb begin
      cx = CW'(cx_out);
      sx = CW'(cy_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wheelbase_ff   <= 12'd768;
         lookahead_ff   <= 16'd1152;
         track_speed_ff <= 12'd240;
         avoid_speed_ff <= 12'd128;
         path_points_ff <= '0;
         mode_ff        <= MODE_TRACK;
         hard_ff        <= 1'b0;
         issuing_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         issuing_ff <= issuing_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WHEELBASE:   wheelbase_ff   <= csr_wdata[11:0];
               CSR_LOOKAHEAD:   lookahead_ff   <= csr_wdata;
               CSR_TRACK_SPEED: track_speed_ff <= csr_wdata[11:0];
               CSR_AVOID_SPEED: avoid_speed_ff <= csr_wdata[11:0];
               CSR_PATH_POINTS: path_points_ff <= csr_wdata[PTS_W-1:0];
               default: ;
            endcase
         end
         // Mode flags; unknown flag values leave the mode alone
         priority if (flag_acc) begin
            unique case (req_data.mode_flag)
               FLAG_TRACK: begin
                  mode_ff <= MODE_TRACK;
                  hard_ff <= 1'b0;
               end
               FLAG_LEFT:  mode_ff <= MODE_LEFT;
               FLAG_RIGHT: mode_ff <= MODE_RIGHT;
               FLAG_HARD: begin
                  mode_ff <= MODE_RIGHT;
                  hard_ff <= 1'b1;
               end
               default: ;
            endcase
         end else if (hard_clear) begin
            hard_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Tick datapath registers
   always_ff @(posedge clock) begin
      near_ff     <= near_in;
      bd_ff       <= bd_in;
      scan_idx_ff <= scan_idx_in;
      if (tick_acc) begin
         vx_ff   <= req_data.vehicle_x;
         vy_ff   <= req_data.vehicle_y;
         flip_ff <= flip_in;
         n_ff    <= n_in;
         la2_ff  <= lookahead_ff * lookahead_ff;
      end
      if ((state_ff == ST_HEAD) && cdone) begin
         c_ff <= flip_ff ? -cx : cx;
         s_ff <= flip_ff ? -sx : sx;
      end
      if ((state_ff == ST_SIN) && cdone) begin
         prod_ff <= $signed({1'b0, wheelbase_ff, 1'b0}) * sx;
      end
      if (res_set) begin
         res_ff <= res_in;
      end
      if (rsp_load) begin
         rsp_ff <= {res_ff.steering, res_ff.speed, res_ff.status, 10'(near_ff)};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   pps_path_ram #(
      .WIDTH (PT_W),
      .DEPTH (PATH_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(req_data.point_index)),
      .wdata ({req_data.point_x, req_data.point_y}),
      .raddr (scan_idx_ff),
      .rdata (rdata)
   );

   pps_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .flush      (!scanning),
      .issue_v    (issue_v),
      .issue_last (issue_last),
      .issue_idx  (scan_idx_ff),
      .rdata      (rdata),
      .vx         (vx_ff),
      .vy         (vy_ff),
      .c          (c_ff),
      .s          (s_ff),
      .res        (sr)
   );

   pps_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (creq),
      .done  (cdone),
      .x_out (cx_out),
      .y_out (cy_out),
      .z_out (cz_out)
   );

endmodule

// File: rtl/pps_checker.sv
// Port-level checks for the steering unit, bound to the top level.
// Depends on pps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pps_checker import pps_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_data
);

   // A stalled result transfer holds its payload
   `PPS_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data),
      "result changed while stalled")

   // A new result comes only out of a busy tick
   `PPS_ASSERT(a_rsp_after_tick, clock, reset, $rose(rsp_valid) |-> $past(req_stall),
      "result without a tick in progress")

   // Stops carry zero steering and zero speed
   `PPS_NEVER(a_stop_zero, clock, reset,
      rsp_valid && (rsp_data.status == STAT_EMPTY || rsp_data.status == STAT_NOFWD) &&
      (rsp_data.steering != '0 || rsp_data.speed != '0),
      "stop with nonzero command")

   // Avoid results use one of the fixed steering values
   `PPS_NEVER(a_avoid_steer, clock, reset,
      rsp_valid && rsp_data.status == STAT_AVOID && rsp_data.steering != ONE_Q13 &&
      rsp_data.steering != PT8_Q13 && rsp_data.steering != PT2_Q13,
      "bad avoid steering")

endmodule

bind pure_pursuit_steering_unit pps_checker u_pps_checker (.*);
